/* rtl/lr_pkg.sv */
package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    MODE_VERT       = 3'd0,
    MODE_HORIZ      = 3'd1,
    MODE_SHALLOW_UP = 3'd2,
    MODE_STEEP_UP   = 3'd3,
    MODE_SHALLOW_DN = 3'd4,
    MODE_STEEP_DN   = 3'd5
  } mode_t;

  typedef struct packed {
    op_t    operation;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t red_in;
    color_t green_in;
    color_t blue_in;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t red_out;
    color_t green_out;
    color_t blue_out;
    logic   final_pixel;
  } out_word_t;

  // error terms are two's complement, ERR_BITS wide
  typedef struct packed {
    logic   drawing;
    mode_t  mode;
    coord_t cursor_x;
    coord_t cursor_y;
    coord_t stop_coord;
    err_t   error_term;
    err_t   step_straight;
    err_t   step_diagonal;
    color_t red;
    color_t green;
    color_t blue;
  } line_state_t;

endpackage

/* rtl/lr_setup.sv */
module lr_setup (
  input  lr_pkg::in_word_t    word,
  output lr_pkg::line_state_t st
);
  import lr_pkg::*;

  localparam int PAD = ERR_BITS - COORD_BITS;

  logic   swap;
  coord_t ax, ay, bx, by;
  err_t   ax_e, ay_e, bx_e, by_e;
  err_t   dx, dy, ndy, dx2, dy2;
  logic   dy_neg, dy_zero, dx_zero;
  logic   y_lower_a;

  assign swap = word.start_x > word.end_x;
  assign ax = swap ? word.end_x : word.start_x;
  assign ay = swap ? word.end_y : word.start_y;
  assign bx = swap ? word.start_x : word.end_x;
  assign by = swap ? word.start_y : word.end_y;

  assign ax_e = {{PAD{1'b0}}, ax};
  assign ay_e = {{PAD{1'b0}}, ay};
  assign bx_e = {{PAD{1'b0}}, bx};
  assign by_e = {{PAD{1'b0}}, by};

  assign dx  = bx_e - ax_e;
  assign dy  = by_e - ay_e;
  assign ndy = ay_e - by_e;
  assign dx2 = {dx[ERR_BITS-2:0], 1'b0};
  assign dy2 = {dy[ERR_BITS-2:0], 1'b0};

  assign dx_zero   = (ax == bx);
  assign dy_zero   = (ay == by);
  assign dy_neg    = dy[ERR_BITS-1];
  assign y_lower_a = (ay <= by);

  always_comb begin
    st               = '0;
    st.drawing       = 1'b1;
    st.red           = word.red_in;
    st.green         = word.green_in;
    st.blue          = word.blue_in;
    st.cursor_x      = ax;
    st.cursor_y      = ay;
    st.stop_coord    = bx;
    if (dx_zero) begin
      st.mode       = MODE_VERT;
      st.cursor_y   = y_lower_a ? ay : by;
      st.stop_coord = y_lower_a ? by : ay;
    end else if (dy_zero) begin
      st.mode = MODE_HORIZ;
    end else if (!dy_neg) begin
      if ($unsigned(dy) <= $unsigned(dx)) begin
        st.mode          = MODE_SHALLOW_UP;
        st.error_term    = dy2 - dx;
        st.step_straight = dy2;
        st.step_diagonal = dy2 - dx2;
      end else begin
        st.mode          = MODE_STEEP_UP;
        st.stop_coord    = by;
        st.error_term    = dx2 - dy;
        st.step_straight = dx2;
        st.step_diagonal = dx2 - dy2;
      end
    end else begin
      if ($unsigned(dx) >= $unsigned(ndy)) begin
        st.mode          = MODE_SHALLOW_DN;
        st.error_term    = (err_t'(0) - dy2) - dx;
        st.step_straight = err_t'(0) - dy2;
        st.step_diagonal = (err_t'(0) - dy2) - dx2;
      end else begin
        st.mode          = MODE_STEEP_DN;
        st.stop_coord    = by;
        st.error_term    = dx2 + dy;
        st.step_straight = dx2;
        st.step_diagonal = dy2 + dx2;
      end
    end
  end

endmodule

/* rtl/lr_step.sv */
module lr_step (
  input  lr_pkg::line_state_t st,
  output lr_pkg::out_word_t   pix,
  output lr_pkg::line_state_t st_nxt
);
  import lr_pkg::*;

  logic   y_major;
  logic   last;
  logic   err_pos;
  err_t   err_straight, err_diag;
  coord_t x_inc, y_inc, y_dec;

  assign y_major = (st.mode == MODE_VERT) || (st.mode == MODE_STEEP_UP) ||
                   (st.mode == MODE_STEEP_DN);
  assign last    = y_major ? (st.cursor_y == st.stop_coord)
                           : (st.cursor_x == st.stop_coord);
  assign err_pos = !st.error_term[ERR_BITS-1] && (st.error_term != '0);

  assign err_straight = st.error_term + st.step_straight;
  assign err_diag     = st.error_term + st.step_diagonal;
  assign x_inc        = st.cursor_x + coord_t'(1);
  assign y_inc        = st.cursor_y + coord_t'(1);
  assign y_dec        = st.cursor_y - coord_t'(1);

  always_comb begin
    pix.pixel_x     = st.cursor_x;
    pix.pixel_y     = st.cursor_y;
    pix.red_out     = st.red;
    pix.green_out   = st.green;
    pix.blue_out    = st.blue;
    pix.final_pixel = last;
  end

  always_comb begin
    st_nxt = st;
    if (last) begin
      st_nxt.drawing = 1'b0;
    end else begin
      case (st.mode)
        MODE_VERT: begin
          st_nxt.cursor_y = y_inc;
        end
        MODE_HORIZ: begin
          st_nxt.cursor_x = x_inc;
        end
        MODE_SHALLOW_UP, MODE_SHALLOW_DN: begin
          st_nxt.cursor_x   = x_inc;
          st_nxt.error_term = err_pos ? err_diag : err_straight;
          if (err_pos) begin
            st_nxt.cursor_y = (st.mode == MODE_SHALLOW_UP) ? y_inc : y_dec;
          end
        end
        default: begin
          st_nxt.cursor_y   = (st.mode == MODE_STEEP_UP) ? y_inc : y_dec;
          st_nxt.error_term = err_pos ? err_diag : err_straight;
          if (err_pos) begin
            st_nxt.cursor_x = x_inc;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/line_rasterizer.sv */
// Bresenham line rasterizer.
// Input channel (in_valid/in_stall/in_word): a start word loads both endpoints
// and the color and returns nothing; each advance word returns one pixel of
// the line on the output channel, final_pixel set on the last one. Advance
// words while no line is active, or after the last pixel, return nothing.
// A start word drops any line in progress.
// Output channel (out_valid/out_stall/out_word) is fed from an output register
// backed by a one-word skid register.
// A pixel is registered into out_word, or into the skid register while the
// output word is held. Throughput: one word per cycle while in_stall is low,
// set by the single add/compare step of the line state register.
// Receiver stall: the output word holds; one more result lands in the skid
// register, after which in_stall is raised until the skid drains.
// Reset (rst_n low, synchronous): no line active, both output registers empty.
module line_rasterizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lr_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output lr_pkg::out_word_t out_word
);
  import lr_pkg::*;

  line_state_t st_r, st_nxt, setup_st, step_st;
  out_word_t   step_pix;
  out_word_t   out_r, out_nxt, skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic        in_accept, res_valid, out_ready;

  lr_setup u_setup (
    .word (in_word),
    .st   (setup_st)
  );

  lr_step u_step (
    .st     (st_r),
    .pix    (step_pix),
    .st_nxt (step_st)
  );

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign res_valid = in_accept && (in_word.operation == OP_ADVANCE) && st_r.drawing;
  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt = st_r;
    if (in_accept) begin
      if (in_word.operation == OP_START) begin
        st_nxt = setup_st;
      end else if (st_r.drawing) begin
        st_nxt = step_st;
      end
    end
  end

  // skid is only loaded while the output word is held, and in_stall is
  // high whenever it is full, so no result arrives while it drains
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = step_pix;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = step_pix;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("pixel lost while output stalled");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_word.operation == OP_START) |=> st_r.drawing)
    else $error("start word did not arm a line");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && step_pix.final_pixel) |=> !st_r.drawing)
    else $error("line still active after final pixel");

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_word.operation == OP_ADVANCE && !st_r.drawing) |=> $stable(st_r))
    else $error("idle advance changed line state");

endmodule
